@@ sv/bsr_pkg.sv @@
package bsr_pkg;
   localparam int DefMaxVars  = 64;
   localparam int DefMaxWords = 1024;
   localparam int CntW        = 17;
   localparam int IdW         = 16;
   localparam int ModeW       = 2;
   localparam logic [ModeW-1:0] ModeConf    = 2'd0;
   localparam logic [ModeW-1:0] ModeSupport = 2'd1;

   // per-row entry of the ranking table
   typedef struct packed {
      logic [IdW-1:0]  id;
      logic [CntW-1:0] shared;
      logic [CntW-1:0] ones;
   } entry_type;

   // saturating counter add
   function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                               input logic [6:0] b,
                                               input logic [CntW:0] cap);
      logic [CntW:0] s;
      s = {1'b0, a} + {{(CntW-6){1'b0}}, b};
      sat_add = (s > cap) ? cap[CntW-1:0] : s[CntW-1:0];
   endfunction
endpackage

@@ sv/bitset_rule_score_ranker_core.sv @@
// bitset rule score ranker
// req channel: one transfer per 64-bit word pair of a variable and target.
// the block counts the variable's ones, the ones shared with the target and
// (during the first variable) the target's ones. word_last closes a variable;
// var_last closes the run and starts the ranking.
// accumulation takes one word per accepted transfer; req_tready is high every cycle
// while the block is not ranking or emitting.
// ranking is a selection sort on a single cross-multiply compare unit:
// each pass loads entry i in StRd and StLd, then does one table read and
// compare per cycle for the rest of the table in StCmp, then swaps in StSwA
// and StSwB.
// results then leave one at a time on rsp, in descending score order,
// rank_last marking the lowest ranked. a stalled rsp_tready holds the
// current result. csr_we writes score_mode (0 confidence, 1 support,
// 2 or 3 raw shared count) and must only be used while idle.
// reset clears counts, variable count and mode; the tables are not cleared.
module bitset_rule_score_ranker_core
   import bsr_pkg::*;
#(
   parameter int MAX_VARS  = DefMaxVars,
   parameter int MAX_WORDS = DefMaxWords
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // var_id[15:0], row_word[79:16], target_word[143:80]
   input  logic [143:0] req_tdata,
   // var_last
   input  logic         req_tuser,
   input  logic         req_tlast,   // word_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // ranked_id[15:0], shared_count[32:16], ones_count[49:33], zero pad
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tlast    // rank_last
);
   localparam int AW = $clog2(MAX_VARS);
   localparam int VW = $clog2(MAX_VARS + 1);
   localparam logic [CntW:0] Cap =
      ((MAX_WORDS * 64) < 131071) ? (CntW+1)'(MAX_WORDS * 64) : (CntW+1)'(131071);

   localparam logic [2:0] StAcc = 3'd0, StRd = 3'd1, StCmp = 3'd2,
                          StSwA = 3'd3, StSwB = 3'd4, StOut = 3'd5, StOutW = 3'd6,
                          StLd = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [ModeW-1:0] mode_ff;
   logic [CntW-1:0] sh_ff, on_ff, tg_ff;
   logic tdone_ff;
   logic [VW-1:0] cnt_ff;
   logic [AW-1:0] i_ff, j_ff, best_ff;
   entry_type best_e_ff, i_e_ff, rd_ff;
   entry_type mem [MAX_VARS];
   logic [AW-1:0] raddr;
   logic beats;

   logic [15:0] id_w;
   logic [63:0] row_w, tgt_w;
   logic acc_go, close;
   logic [CntW-1:0] sh_n, on_n;

   assign id_w  = req_tdata[15:0];
   assign row_w = req_tdata[79:16];
   assign tgt_w = req_tdata[143:80];
   assign req_tready = (state_ff == StAcc);
   assign acc_go = req_tvalid && req_tready;
   assign close  = req_tlast || req_tuser;
   assign sh_n = sat_add(sh_ff, 7'($countones(row_w & tgt_w)), Cap);
   assign on_n = sat_add(on_ff, 7'($countones(row_w)), Cap);

   bsr_cmp u_cmp (
      .mode(mode_ff), .target_cnt(tg_ff), .a(rd_ff), .b(best_e_ff), .beats(beats)
   );

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= ModeConf;
      else if (csr_we) mode_ff <= csr_wdata;
   end

   // read address of the single table read port, one entry ahead of the compare
   always_comb begin
      case (state_ff)
         StLd:    raddr = i_ff + 1'b1;
         StCmp:   raddr = j_ff + 1'b1;
         default: raddr = i_ff;
      endcase
   end

   logic last_j, last_i;
   assign last_j = ({1'b0, j_ff} + 1'b1) >= (AW+1)'(cnt_ff);
   assign last_i = ({2'b0, i_ff} + (AW+2)'(2)) >= (AW+2)'(cnt_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StAcc:  if (acc_go && req_tuser) state_in = (cnt_ff > 1 || (cnt_ff < VW'(MAX_VARS)
                                             && cnt_ff == 1)) ? StRd : StOutW;
         StRd:   state_in = StLd;
         StLd:   state_in = StCmp;
         StCmp:  state_in = last_j ? StSwA : StCmp;
         StSwA:  state_in = StSwB;
         StSwB:  state_in = last_i ? StOutW : StRd;
         StOutW: state_in = StOut;
         StOut:  if (rsp_tready) state_in = (({1'b0, i_ff} + 1'b1) >= (AW+1)'(cnt_ff))
                                             ? StAcc : StOutW;
         default: state_in = StAcc;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (acc_go && close && cnt_ff < VW'(MAX_VARS))
         mem[cnt_ff[AW-1:0]] <= '{id: id_w, shared: sh_n, ones: on_n};
      else if (state_ff == StSwA) mem[i_ff] <= best_e_ff;
      else if (state_ff == StSwB) mem[best_ff] <= i_e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StAcc;
         sh_ff <= '0; on_ff <= '0; tg_ff <= '0; tdone_ff <= 1'b0;
         cnt_ff <= '0; i_ff <= '0; j_ff <= '0; best_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            StAcc: if (acc_go) begin
               if (!tdone_ff) tg_ff <= sat_add(tg_ff, 7'($countones(tgt_w)), Cap);
               if (close) begin
                  sh_ff <= '0; on_ff <= '0; tdone_ff <= 1'b1;
                  if (cnt_ff < VW'(MAX_VARS)) cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  sh_ff <= sh_n; on_ff <= on_n;
               end
               i_ff <= '0; j_ff <= '0; best_ff <= '0;
            end
            StLd: begin
               // rd_ff now holds entry i
               best_e_ff <= rd_ff; i_e_ff <= rd_ff; best_ff <= i_ff;
               j_ff <= i_ff + 1'b1;
            end
            StCmp: begin
               if (j_ff != i_ff && beats) begin
                  best_e_ff <= rd_ff; best_ff <= j_ff;
               end
               if (!last_j) j_ff <= j_ff + 1'b1;
            end
            StSwB: begin
               if (last_i) i_ff <= '0;
               else i_ff <= i_ff + 1'b1;
               j_ff <= i_ff + 1'b1;
            end
            StOut: if (rsp_tready) begin
               if (({1'b0, i_ff} + 1'b1) >= (AW+1)'(cnt_ff)) begin
                  cnt_ff <= '0; tg_ff <= '0; tdone_ff <= 1'b0; i_ff <= '0;
               end else i_ff <= i_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == StOut) && (cnt_ff != '0);
   assign rsp_tdata  = {6'b0, rd_ff.ones, rd_ff.shared, rd_ff.id};
   assign rsp_tlast  = ({1'b0, i_ff} + 1'b1) == (AW+1)'(cnt_ff);

`ifndef SYNTH
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("rsp while accepting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(i_ff))
      else $error("result lost on stall");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= VW'(MAX_VARS)) else $error("count over");
`endif
endmodule

@@ sv/bsr_cmp.sv @@
// shared compare unit: does a score strictly beat b score
module bsr_cmp
   import bsr_pkg::*;
(
   input  logic [ModeW-1:0] mode,
   input  logic [CntW-1:0]  target_cnt,
   input  entry_type        a,
   input  entry_type        b,
   output logic             beats
);
   logic [CntW-1:0] da, db, na, nb;
   logic [2*CntW-1:0] lhs, rhs;

   always_comb begin
      if (mode == ModeConf) begin
         da = a.ones;
         db = b.ones;
      end else if (mode == ModeSupport) begin
         da = target_cnt;
         db = target_cnt;
      end else begin
         da = CntW'(1);
         db = CntW'(1);
      end
      na = a.shared;
      nb = b.shared;
      if (da == '0) begin
         na = '0;
         da = CntW'(1);
      end
      if (db == '0) begin
         nb = '0;
         db = CntW'(1);
      end
      lhs   = na * db;
      rhs   = nb * da;
      beats = lhs > rhs;
   end
endmodule
